/* rtl/core/rsf_pkg.sv */
package rsf_pkg;

    typedef struct packed {
        logic               command;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } rsf_in_t;

    typedef struct packed {
        logic signed [31:0] bias_x;
        logic signed [31:0] bias_y;
        logic signed [31:0] bias_z;
        logic        [31:0] radius;
        logic               radius_valid;
    } rsf_out_t;

    localparam logic [1:0]  CFG_FORGET   = 2'd0;
    localparam logic [1:0]  CFG_INIT_COV = 2'd1;
    localparam logic [15:0] FORGET_RESET   = 16'd65470;
    localparam logic [10:0] INIT_COV_RESET = 11'd1000;
    localparam logic        CMD_RESTART    = 1'b1;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

endpackage

/* rtl/core/rls_sphere_fit.sv */
// Recursive least squares sphere fit for magnetometer hard-iron calibration.
// Input words arrive on s_valid/s_ready/s_data: command 0 updates the fit with
// the sample, command 1 restarts it (estimate cleared, covariance diagonal
// reloaded). Every input word yields exactly one result word on
// m_valid/m_ready/m_data: the three offsets, the radius and its valid flag.
// The registers (forgetting factor, initial covariance) are written through
// cfg_we/cfg_index/cfg_wdata; the user must do so only while the block is
// idle, as the block does not enforce it. One arithmetic datapath is shared
// under a sequencer: a 33x33 multiplier builds each 64x64 product in four
// passes, a restoring divider produces one quotient bit per cycle, and a
// square root takes one result bit per cycle. An update is dominated by the
// twenty bit-serial divisions (102 steps for each gain, 80 for each
// covariance entry). s_ready is high only while idle.
// The result sits in an output register; if the receiver stalls, the next
// word can still be accepted, and the sequencer holds its finished result
// until the register frees up. Reset restores the register defaults, clears
// the estimate and loads the covariance diagonal.
module rls_sphere_fit
    import rsf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  rsf_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rsf_out_t   m_data
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_SQ   = 13'b0000000000010,
        ST_PH   = 13'b0000000000100,
        ST_HPH  = 13'b0000000001000,
        ST_CHK  = 13'b0000000010000,
        ST_KDIV = 13'b0000000100000,
        ST_HTH  = 13'b0000001000000,
        ST_EST  = 13'b0000010000000,
        ST_COVM = 13'b0000100000000,
        ST_COVD = 13'b0001000000000,
        ST_RAD  = 13'b0010000000000,
        ST_SQRT = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg;

    logic [15:0] ff_reg;
    logic [10:0] ic_reg;

    logic signed [63:0] cov_reg [16];
    logic signed [63:0] est_reg [4];
    logic signed [63:0] ph_reg  [4];
    logic signed [63:0] k_reg   [4];
    logic signed [63:0] smp_reg [3];
    logic signed [63:0] w_reg, hph_reg, den_reg, hth_reg, err_reg, dnum_reg, rad_reg;
    logic [3:0]   idx_reg;
    logic [2:0]   mk_reg;
    logic signed [127:0] acc_reg;

    logic         dv_run_reg, dv_done_reg, dv_neg_reg, dv_over_reg;
    logic [6:0]   dv_cnt_reg;
    logic [63:0]  dv_r_reg, dv_q_reg;
    logic [127:0] dv_dvd_reg;

    logic [64:0]  sq_t_reg, sq_one_reg;
    logic [65:0]  sq_res_reg;
    logic [5:0]   sq_cnt_reg;
    logic [31:0]  radius_reg;
    logic         rvalid_reg;

    logic         m_valid_reg;
    rsf_out_t     m_data_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    function automatic logic signed [63:0] samp(input logic [15:0] v);
        logic [23:0]             z;
        logic [SAMPLE_WIDTH-1:0] t;
        z = {8'b0, v};
        t = z[SAMPLE_WIDTH-1:0];
        return 64'(signed'(t));
    endfunction

    function automatic logic [31:0] ofs32(input logic signed [63:0] e);
        logic signed [63:0] o;
        o = e >>> 14;
        if ((&o[63:31]) || !(|o[63:31])) begin
            return o[31:0];
        end
        return o[63] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // Shared operand selection.
    logic signed [63:0] smp_at, h_at, mul_a, mul_b;
    logic [6:0]         mul_sh;
    logic               mul_state;

    always_comb begin
        unique case (idx_reg[1:0])
            2'd0:    smp_at = smp_reg[0];
            2'd1:    smp_at = smp_reg[1];
            default: smp_at = smp_reg[2];
        endcase
        h_at = (idx_reg[1:0] == 2'd3) ? 64'sd1 : (smp_at <<< 1);
    end

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = 7'd0;
        unique case (state_reg)
            ST_SQ: begin
                mul_a = smp_at; mul_b = smp_at; mul_sh = 7'd0;
            end
            ST_PH: begin
                mul_a = cov_reg[idx_reg]; mul_b = h_at; mul_sh = 7'd22;
            end
            ST_HPH: begin
                mul_a = h_at; mul_b = ph_reg[idx_reg[1:0]]; mul_sh = 7'd14;
            end
            ST_HTH: begin
                mul_a = h_at; mul_b = est_reg[idx_reg[1:0]]; mul_sh = 7'd0;
            end
            ST_EST: begin
                mul_a = k_reg[idx_reg[1:0]]; mul_b = err_reg; mul_sh = 7'd52;
            end
            ST_COVM: begin
                mul_a = k_reg[idx_reg[3:2]]; mul_b = ph_reg[idx_reg[1:0]];
                mul_sh = 7'd30;
            end
            ST_RAD: begin
                mul_a = est_reg[idx_reg[1:0]]; mul_b = est_reg[idx_reg[1:0]];
                mul_sh = 7'd30;
            end
            default: begin
                mul_sh = 7'd0;
            end
        endcase
    end

    assign mul_state = (state_reg == ST_SQ) || (state_reg == ST_PH) ||
                       (state_reg == ST_HPH) || (state_reg == ST_HTH) ||
                       (state_reg == ST_EST) || (state_reg == ST_COVM) ||
                       (state_reg == ST_RAD);

    // One 33x33 partial product per pass; four passes make the 128-bit product.
    logic signed [32:0]  pa, pb;
    logic signed [65:0]  pp;
    logic signed [127:0] pp_sh, acc_sh;
    logic signed [63:0]  prod;

    always_comb begin
        pa = mk_reg[1] ? {mul_a[63], mul_a[63:32]} : {1'b0, mul_a[31:0]};
        pb = mk_reg[0] ? {mul_b[63], mul_b[63:32]} : {1'b0, mul_b[31:0]};
        pp = pa * pb;
        unique case (mk_reg[1:0])
            2'd0:    pp_sh = 128'(pp);
            2'd3:    pp_sh = 128'(pp) <<< 64;
            default: pp_sh = 128'(pp) <<< 32;
        endcase
        acc_sh = acc_reg >>> mul_sh;
        if ((&acc_sh[127:63]) || !(|acc_sh[127:63])) begin
            prod = acc_sh[63:0];
        end else begin
            prod = acc_sh[127] ? S64_MIN : S64_MAX;
        end
    end

    logic signed [63:0] lam, den_calc, w_q, ph_new, hph_new, hth_new, rad_new, d_new;
    always_comb begin
        lam      = {48'b0, (ff_reg == 16'd0) ? 16'd1 : ff_reg};
        den_calc = sadd64(lam, hph_reg);
        w_q      = (|w_reg[63:33]) ? S64_MAX : (w_reg <<< 30);
        ph_new   = sadd64(ph_reg[idx_reg[3:2]], prod);
        hph_new  = sadd64(hph_reg, prod);
        hth_new  = sadd64(hth_reg, prod);
        rad_new  = sadd64(rad_reg, prod);
        d_new    = ssub64(cov_reg[idx_reg], prod);
    end

    // Restoring divider operands and one step.
    logic signed [63:0] dv_num;
    logic [6:0]         dv_sh;
    logic [63:0]        dv_den, dv_mag, dv_res;
    logic [64:0]        dv_rs;
    logic               dv_qbit;

    always_comb begin
        if (state_reg == ST_KDIV) begin
            dv_num = ph_reg[idx_reg[1:0]];
            dv_sh  = 7'd38;
            dv_den = den_reg;
        end else begin
            dv_num = dnum_reg;
            dv_sh  = 7'd16;
            dv_den = lam;
        end
        dv_mag  = dv_num[63] ? (64'd0 - dv_num) : dv_num;
        dv_rs   = {dv_r_reg, dv_dvd_reg[dv_cnt_reg]};
        dv_qbit = (dv_rs >= {1'b0, dv_den});
        if (dv_over_reg) begin
            dv_res = dv_neg_reg ? S64_MIN : S64_MAX;
        end else begin
            dv_res = dv_neg_reg ? (64'd0 - dv_q_reg) : dv_q_reg;
        end
    end

    // Digit-by-digit square root step.
    logic [65:0] sq_trial, sq_res_step;
    logic [64:0] sq_t_step;
    always_comb begin
        sq_trial = sq_res_reg + {1'b0, sq_one_reg};
        if ({1'b0, sq_t_reg} >= sq_trial) begin
            sq_t_step   = sq_t_reg - sq_trial[64:0];
            sq_res_step = (sq_res_reg >> 1) + {1'b0, sq_one_reg};
        end else begin
            sq_t_step   = sq_t_reg;
            sq_res_step = sq_res_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ff_reg      <= FORGET_RESET;
            ic_reg      <= INIT_COV_RESET;
            idx_reg     <= '0;
            mk_reg      <= '0;
            dv_run_reg  <= 1'b0;
            dv_done_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int n = 0; n < 4; n++) begin
                est_reg[n] <= '0;
            end
            for (int n = 0; n < 16; n++) begin
                cov_reg[n] <= (n % 5 == 0) ? {1'b0, INIT_COV_RESET, 52'b0} : '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_FORGET) begin
                    ff_reg <= cfg_wdata;
                end else if (cfg_index == CFG_INIT_COV) begin
                    ic_reg <= cfg_wdata[10:0];
                end
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (mul_state && mk_reg != 3'd4) begin
                acc_reg <= ((mk_reg == 3'd0) ? 128'sd0 : acc_reg) + pp_sh;
                mk_reg  <= mk_reg + 3'd1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        smp_reg[0] <= samp(s_data.mag_x);
                        smp_reg[1] <= samp(s_data.mag_y);
                        smp_reg[2] <= samp(s_data.mag_z);
                        idx_reg    <= '0;
                        mk_reg     <= '0;
                        if (s_data.command == CMD_RESTART) begin
                            for (int n = 0; n < 4; n++) begin
                                est_reg[n] <= '0;
                            end
                            for (int n = 0; n < 16; n++) begin
                                cov_reg[n] <= (n % 5 == 0) ? {1'b0, ic_reg, 52'b0} : '0;
                            end
                            rad_reg   <= '0;
                            state_reg <= ST_RAD;
                        end else begin
                            w_reg     <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg  <= '0;
                        w_reg   <= w_reg + prod;
                        if (idx_reg[1:0] == 2'd2) begin
                            idx_reg   <= '0;
                            for (int n = 0; n < 4; n++) begin
                                ph_reg[n] <= '0;
                            end
                            state_reg <= ST_PH;
                        end else begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                ST_PH: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg                <= '0;
                        ph_reg[idx_reg[3:2]]  <= ph_new;
                        idx_reg               <= idx_reg + 4'd1;
                        if (idx_reg == 4'd15) begin
                            hph_reg   <= '0;
                            state_reg <= ST_HPH;
                        end
                    end
                end
                ST_HPH: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg  <= '0;
                        hph_reg <= hph_new;
                        if (idx_reg[1:0] == 2'd3) begin
                            idx_reg   <= '0;
                            state_reg <= ST_CHK;
                        end else begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                ST_CHK: begin
                    den_reg <= den_calc;
                    if (den_calc[63] || den_calc == 64'sd0) begin
                        // Degenerate denominator: keep the state, just report it.
                        rad_reg   <= est_reg[3];
                        state_reg <= ST_RAD;
                    end else begin
                        state_reg <= ST_KDIV;
                    end
                end
                ST_KDIV, ST_COVD: begin
                    if (dv_done_reg) begin
                        dv_done_reg <= 1'b0;
                        if (state_reg == ST_KDIV) begin
                            k_reg[idx_reg[1:0]] <= dv_res;
                            if (idx_reg[1:0] == 2'd3) begin
                                idx_reg   <= '0;
                                hth_reg   <= '0;
                                state_reg <= ST_HTH;
                            end else begin
                                idx_reg <= idx_reg + 4'd1;
                            end
                        end else begin
                            cov_reg[idx_reg] <= dv_res;
                            if (idx_reg == 4'd15) begin
                                idx_reg   <= '0;
                                rad_reg   <= est_reg[3];
                                state_reg <= ST_RAD;
                            end else begin
                                idx_reg   <= idx_reg + 4'd1;
                                state_reg <= ST_COVM;
                            end
                        end
                    end else if (dv_run_reg) begin
                        dv_r_reg <= dv_qbit ? 64'(dv_rs - {1'b0, dv_den}) : dv_rs[63:0];
                        dv_q_reg <= {dv_q_reg[62:0], dv_qbit};
                        if (dv_qbit && dv_cnt_reg >= 7'd63) begin
                            dv_over_reg <= 1'b1;
                        end
                        dv_cnt_reg <= dv_cnt_reg - 7'd1;
                        if (dv_cnt_reg == 7'd0) begin
                            dv_run_reg  <= 1'b0;
                            dv_done_reg <= 1'b1;
                        end
                    end else begin
                        dv_neg_reg  <= dv_num[63];
                        dv_dvd_reg  <= {64'b0, dv_mag} << dv_sh;
                        dv_cnt_reg  <= 7'd63 + dv_sh;
                        dv_r_reg    <= '0;
                        dv_q_reg    <= '0;
                        dv_over_reg <= 1'b0;
                        dv_run_reg  <= 1'b1;
                    end
                end
                ST_HTH: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg  <= '0;
                        hth_reg <= hth_new;
                        if (idx_reg[1:0] == 2'd3) begin
                            idx_reg   <= '0;
                            err_reg   <= ssub64(w_q, hth_new);
                            state_reg <= ST_EST;
                        end else begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                ST_EST: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg                <= '0;
                        est_reg[idx_reg[1:0]] <= sadd64(est_reg[idx_reg[1:0]], prod);
                        if (idx_reg[1:0] == 2'd3) begin
                            idx_reg   <= '0;
                            state_reg <= ST_COVM;
                        end else begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                ST_COVM: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg    <= '0;
                        dnum_reg  <= d_new;
                        state_reg <= ST_COVD;
                    end
                end
                ST_RAD: begin
                    if (mk_reg == 3'd4) begin
                        mk_reg  <= '0;
                        rad_reg <= rad_new;
                        if (idx_reg[1:0] == 2'd2) begin
                            idx_reg <= '0;
                            if (rad_new[63]) begin
                                radius_reg <= '0;
                                rvalid_reg <= 1'b0;
                                state_reg  <= ST_OUT;
                            end else begin
                                sq_t_reg   <= {rad_new[62:0], 2'b00};
                                sq_res_reg <= '0;
                                sq_one_reg <= {1'b1, 64'b0};
                                sq_cnt_reg <= 6'd32;
                                state_reg  <= ST_SQRT;
                            end
                        end else begin
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                end
                ST_SQRT: begin
                    sq_t_reg   <= sq_t_step;
                    sq_res_reg <= sq_res_step;
                    sq_one_reg <= sq_one_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg - 6'd1;
                    if (sq_cnt_reg == 6'd0) begin
                        radius_reg <= (|sq_res_step[65:32]) ? 32'hffff_ffff
                                                            : sq_res_step[31:0];
                        rvalid_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.bias_x       <= ofs32(est_reg[0]);
                        m_data_reg.bias_y       <= ofs32(est_reg[1]);
                        m_data_reg.bias_z       <= ofs32(est_reg[2]);
                        m_data_reg.radius       <= radius_reg;
                        m_data_reg.radius_valid <= rvalid_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    import rsf_pkg::*;

    typedef logic signed [63:0]  s64_t;
    typedef logic signed [127:0] s128_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    rsf_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    rsf_out_t   m_data;

    rls_sphere_fit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Fit state mirrored by the predictor.
    logic [15:0] lambda_reg;
    logic [10:0] cov_init_reg;
    s64_t        est[4];
    s64_t        cov[16];

    rsf_in_t  sample_queue[$];
    rsf_out_t fit_due[$];
    int       mismatches;
    int       queued_total;
    bit       calm;
    bit       hold_kick;
    int       hold_left;

    function automatic s64_t clamp64(s128_t v);
        if (v[127:63] == '0 || v[127:63] == '1) begin
            return v[63:0];
        end
        return v[127] ? S64_MIN : S64_MAX;
    endfunction

    function automatic s64_t add_sat(s64_t a, s64_t b);
        s128_t t;
        t = s128_t'(a) + s128_t'(b);
        return clamp64(t);
    endfunction

    function automatic s64_t sub_sat(s64_t a, s64_t b);
        s128_t t;
        t = s128_t'(a) - s128_t'(b);
        return clamp64(t);
    endfunction

    // floor(a*b / 2^sh), saturated.
    function automatic s64_t mul_shift(s64_t a, s64_t b, int sh);
        s128_t p;
        p = s128_t'(a) * s128_t'(b);
        return clamp64(p >>> sh);
    endfunction

    // Quotient truncated toward zero, saturated; den is positive.
    function automatic s64_t div_shift(s64_t num, int sh, s64_t den);
        logic [127:0] mag;
        logic [127:0] q;
        bit           neg;
        neg = num[63];
        mag = neg ? -s128_t'(num) : s128_t'(num);
        q = (mag << sh) / {64'd0, den};
        if (q[127:63] != 0) begin
            return neg ? S64_MIN : S64_MAX;
        end
        return neg ? -s64_t'(q[63:0]) : s64_t'(q[63:0]);
    endfunction

    function automatic logic [31:0] sqrt4(s64_t r);
        logic [127:0] t;
        logic [63:0]  y;
        logic [63:0]  c;
        t = {64'd0, r} << 2;
        y = 0;
        for (int b = 32; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= t) begin
                y = c;
            end
        end
        return (y > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : y[31:0];
    endfunction

    function automatic void clear_fit();
        for (int i = 0; i < 4; i++) begin
            est[i] = 0;
        end
        for (int i = 0; i < 16; i++) begin
            cov[i] = (i % 5 == 0) ? s64_t'({53'd0, cov_init_reg}) << 52 : 64'sd0;
        end
    endfunction

    function automatic void fit_sample(s64_t x, s64_t y, s64_t z);
        s64_t h[4];
        s64_t ph[4];
        s64_t k[4];
        s64_t lam, w, hph, den, hth, err, d;
        lam = (lambda_reg == 0) ? 64'sd1 : s64_t'({48'd0, lambda_reg});
        h[0] = 2 * x;
        h[1] = 2 * y;
        h[2] = 2 * z;
        h[3] = 1;
        w = x * x + y * y + z * z;
        hph = 0;
        hth = 0;
        for (int i = 0; i < 4; i++) begin
            ph[i] = 0;
            for (int j = 0; j < 4; j++) begin
                ph[i] = add_sat(ph[i], mul_shift(cov[i*4+j], h[j], 22));
            end
        end
        for (int i = 0; i < 4; i++) begin
            hph = add_sat(hph, mul_shift(h[i], ph[i], 14));
        end
        den = add_sat(lam, hph);
        // A non-positive denominator leaves the state untouched.
        if (den <= 0) begin
            return;
        end
        for (int i = 0; i < 4; i++) begin
            k[i] = div_shift(ph[i], 38, den);
            hth = add_sat(hth, mul_shift(h[i], est[i], 0));
        end
        err = sub_sat(mul_shift(w, 64'sd1 << 30, 0), hth);
        for (int i = 0; i < 4; i++) begin
            est[i] = add_sat(est[i], mul_shift(k[i], err, 52));
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                d = sub_sat(cov[i*4+j], mul_shift(k[i], ph[j], 30));
                cov[i*4+j] = div_shift(d, 16, lam);
            end
        end
    endfunction

    function automatic rsf_out_t predict_fit(rsf_in_t w);
        rsf_out_t r;
        s64_t     rad;
        s64_t     o[3];
        if (w.command == CMD_RESTART) begin
            clear_fit();
        end else begin
            fit_sample(s64_t'(w.mag_x), s64_t'(w.mag_y), s64_t'(w.mag_z));
        end
        rad = est[3];
        for (int i = 0; i < 3; i++) begin
            o[i] = mul_shift(est[i], 64'sd1, 14);
            if (o[i] > 64'sd2147483647) o[i] = 64'sd2147483647;
            if (o[i] < -64'sd2147483648) o[i] = -64'sd2147483648;
            rad = add_sat(rad, mul_shift(est[i], est[i], 30));
        end
        r.bias_x = o[0][31:0];
        r.bias_y = o[1][31:0];
        r.bias_z = o[2][31:0];
        if (rad < 0) begin
            r.radius = 0;
            r.radius_valid = 1'b0;
        end else begin
            r.radius = sqrt4(rad);
            r.radius_valid = 1'b1;
        end
        return r;
    endfunction

    // Sender: one word in flight, random gap after each accepted word.
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                fit_due.push_back(predict_fit(s_data));
                send_gap = calm ? 0 : $urandom_range(0, 5);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started from the stimulus process.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= 5000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver and checker.
    int recv_stall;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (fit_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word %p", m_data);
                    end
                end else begin
                    rsf_out_t want;
                    want = fit_due.pop_front();
                    if (want.bias_x !== m_data.bias_x
                        || want.bias_y !== m_data.bias_y
                        || want.bias_z !== m_data.bias_z
                        || want.radius !== m_data.radius
                        || want.radius_valid !== m_data.radius_valid) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %p, got %p", want, m_data);
                        end
                    end
                end
                recv_stall = calm ? 0 : $urandom_range(0, 5);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_ready <= (recv_stall == 0) && (hold_left == 0) && !hold_kick;
        end
    end

    task automatic queue_word(bit cmd, int x, int y, int z);
        rsf_in_t w;
        w.command = cmd;
        w.mag_x = x[15:0];
        w.mag_y = y[15:0];
        w.mag_z = z[15:0];
        sample_queue.push_back(w);
        queued_total++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_FORGET) lambda_reg = val;
        else if (idx == CFG_INIT_COV) cov_init_reg = val[10:0];
    endtask

    task automatic drain();
        do begin
            @(posedge aclk);
        end while (sample_queue.size() > 0 || s_valid || fit_due.size() > 0 || m_valid);
        repeat (30) @(posedge aclk);
    endtask

    // Restart, then samples on a sphere with random center and radius.
    task automatic queue_sphere_run();
        int  cx, cy, cz, n;
        real rr, ux, uy, uz, len;
        cx = $urandom_range(0, 4000) - 2000;
        cy = $urandom_range(0, 4000) - 2000;
        cz = $urandom_range(0, 4000) - 2000;
        rr = $urandom_range(200, 8000);
        n = $urandom_range(8, 30);
        queue_word(CMD_RESTART, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++) begin
            ux = real'($urandom_range(0, 2000)) - 1000.0;
            uy = real'($urandom_range(0, 2000)) - 1000.0;
            uz = real'($urandom_range(0, 2000)) - 1000.0;
            len = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0;
            queue_word(1'b0,
                       cx + int'(rr * ux / len) + $urandom_range(0, 20) - 10,
                       cy + int'(rr * uy / len) + $urandom_range(0, 20) - 10,
                       cz + int'(rr * uz / len) + $urandom_range(0, 20) - 10);
        end
    endtask

    initial begin
        logic [15:0] lam_set[6];
        logic [10:0] cov_set[6];
        int          start;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        calm = 1'b0;
        hold_kick = 1'b0;
        mismatches = 0;
        queued_total = 0;
        lambda_reg = FORGET_RESET;
        cov_init_reg = INIT_COV_RESET;
        clear_fit();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: fields at their extremes, both commands, restart with junk.
        queue_word(1'b0, 0, 0, 0);
        queue_word(1'b0, 32767, 32767, 32767);
        queue_word(1'b0, -32768, -32768, -32768);
        queue_word(1'b0, 32767, -32768, 0);
        queue_word(CMD_RESTART, -1, 32767, -32768);
        queue_word(1'b0, 1000, 0, 0);
        queue_word(1'b0, -1000, 0, 0);
        queue_word(1'b0, 0, 1000, 0);
        queue_word(1'b0, 0, -1000, 0);
        queue_word(1'b0, 0, 0, 1000);
        queue_word(1'b0, 0, 0, -1000);
        queue_word(1'b0, 21845, -21846, 10922);
        queue_word(CMD_RESTART, 0, 0, 0);
        drain();

        // Writes to unused indexes must leave the fit alone.
        write_reg(2'd2, 16'h1234);
        write_reg(2'd3, 16'hFFFF);
        queue_word(1'b0, 500, -300, 200);
        drain();

        // Fill the block while the receiver holds off.
        @(posedge aclk);
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            queue_word(CMD_RESTART, $urandom, $urandom, $urandom);
            queue_word(1'b0, $urandom_range(0, 4000) - 2000, 100, -100);
        end
        drain();

        lam_set = '{FORGET_RESET, 16'd65535, 16'd58982, 16'd0, 16'd60000, 16'd64000};
        cov_set = '{INIT_COV_RESET, 11'd2047, 11'd1, 11'd0, 11'd1000, 11'd300};
        lam_set[4] = 16'($urandom_range(58982, 65535));
        cov_set[4] = 11'($urandom_range(1, 2047));
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_FORGET, lam_set[p]);
            write_reg(CFG_INIT_COV, {5'd0, cov_set[p]});
            calm = (p == 2);
            start = queued_total;
            while (queued_total - start < 175) begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    queue_sphere_run();
                end else if (pick < 85) begin
                    for (int i = 0; i < 6; i++) begin
                        queue_word($urandom_range(0, 9) == 0, $urandom, $urandom, $urandom);
                    end
                end else begin
                    // Updates with no restart and wild magnitudes.
                    for (int i = 0; i < 6; i++) begin
                        queue_word(1'b0, $urandom_range(0, 65535) - 32768,
                                   $urandom_range(0, 65535) - 32768,
                                   $urandom_range(0, 200) - 100);
                    end
                end
            end
            drain();
        end
        calm = 1'b0;

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && fit_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
